@@ hdl/assert_macros.svh @@
// Assertion macros shared by the tone curve mapper RTL.
// No dependencies; include where concurrent checks are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Antecedent implies consequent in the following cycle.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ hdl/tcm_pkg.sv @@
// Package for the tone curve mapper: field widths, curve ids, opcodes,
// rounding constants and the request and result structs. No dependencies.
package tcm_pkg;

  localparam int FRAC_BITS = 16;
  localparam int IN_W      = 18;
  localparam int OUT_W     = 17;
  localparam int ENTRY_W   = 8;
  localparam int SEL_W     = 3;
  localparam int IDX_W     = 8;
  localparam int BLEND_W   = FRAC_BITS + ENTRY_W;
  localparam int MAP_LAT   = 4;
  localparam int FIFO_DEPTH = 16;

  localparam logic [FRAC_BITS:0] ONE_Q      = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [BLEND_W-1:0] ROUND_BIAS = BLEND_W'(127);

  // floor(x / 255) as (x * RECIP_MUL) >> RECIP_SHIFT, exact for x below 2^24
  localparam int RECIP_SHIFT = 33;
  localparam int RECIP_W     = 26;
  localparam logic [RECIP_W-1:0] RECIP_MUL =
    RECIP_W'((64'd1 << RECIP_SHIFT) / 64'd255 + 64'd1);

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_PIXEL = 1'b1;

  localparam logic [SEL_W-1:0] TBL_OVERALL = 3'd0;
  localparam logic [SEL_W-1:0] TBL_RED     = 3'd1;
  localparam logic [SEL_W-1:0] TBL_GREEN   = 3'd2;
  localparam logic [SEL_W-1:0] TBL_BLUE    = 3'd3;
  localparam logic [SEL_W-1:0] TBL_ALPHA   = 3'd4;

  typedef struct packed {
    logic               en;
    logic [SEL_W-1:0]   sel;
    logic [IDX_W-1:0]   idx;
    logic [ENTRY_W-1:0] data;
  } load_req_t;

  typedef struct packed {
    logic [OUT_W-1:0] red;
    logic [OUT_W-1:0] green;
    logic [OUT_W-1:0] blue;
    logic [OUT_W-1:0] alpha;
    logic             last;
  } pix_res_t;

endpackage

@@ hdl/rgba_tone_curve_mapper.sv @@
// Top level of the RGBA tone curve mapper: input register, four lanes,
// output queue. Uses tcm_pkg, tcm_lane, tcm_out_fifo, assert_macros.svh.
//
//   port group   | handshake              | carries
//   -------------+------------------------+--------------------------------
//   input        | in_valid / in_ready    | curve load or one RGBA pixel
//   output       | out_valid / out_ready  | mapped RGBA pixel and last flag
//
// One request per cycle while in_ready is high; a pixel passes the input
// register, two four-stage curve lookups and the output register.
// Loads make no result and take effect in order.
// Reset clears control only; curve entries are undefined until loaded.
// in_ready drops while 16 pixels are in flight or queued unread.
`include "assert_macros.svh"

module rgba_tone_curve_mapper #(
  parameter int CURVE_ENTRIES = 256
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                opcode,
  input  logic        [tcm_pkg::SEL_W-1:0]    table_select,
  input  logic        [tcm_pkg::IDX_W-1:0]    entry_index,
  input  logic        [tcm_pkg::ENTRY_W-1:0]  entry_value,
  input  logic signed [tcm_pkg::IN_W-1:0]     red_in,
  input  logic signed [tcm_pkg::IN_W-1:0]     green_in,
  input  logic signed [tcm_pkg::IN_W-1:0]     blue_in,
  input  logic signed [tcm_pkg::IN_W-1:0]     alpha_in,
  input  logic                                last_in,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic        [tcm_pkg::OUT_W-1:0]    red_out,
  output logic        [tcm_pkg::OUT_W-1:0]    green_out,
  output logic        [tcm_pkg::OUT_W-1:0]    blue_out,
  output logic        [tcm_pkg::OUT_W-1:0]    alpha_out,
  output logic                                last_out
);
  import tcm_pkg::*;

  localparam int PIPE_LAT = 2 * MAP_LAT;
  localparam int CW       = $clog2(FIFO_DEPTH + 1);

  logic                   in_acc;
  logic                   out_acc;
  logic                   pix_acc;
  logic                   pix_s0;
  logic                   ld_en_s0;
  logic [SEL_W-1:0]       sel_s0;
  logic [IDX_W-1:0]       idx_s0;
  logic [ENTRY_W-1:0]     data_s0;
  logic signed [IN_W-1:0] red_s0;
  logic signed [IN_W-1:0] green_s0;
  logic signed [IN_W-1:0] blue_s0;
  logic signed [IN_W-1:0] alpha_s0;
  logic                   last_s0;
  load_req_t              ld_s0;
  logic [PIPE_LAT-1:0]    pix_pipe;
  logic [PIPE_LAT-1:0]    last_pipe;
  logic [CW-1:0]          pending;
  logic [CW-1:0]          pending_next;
  logic [OUT_W-1:0]       res_red;
  logic [OUT_W-1:0]       res_green;
  logic [OUT_W-1:0]       res_blue;
  logic [OUT_W-1:0]       res_alpha;
  pix_res_t               fifo_in;
  pix_res_t               fifo_out;

  assign in_ready = pending < CW'(FIFO_DEPTH);
  assign in_acc   = in_valid && in_ready;
  assign out_acc  = out_valid && out_ready;
  assign pix_acc  = in_acc && (opcode == OP_PIXEL);

  always_comb begin
    pending_next = pending;
    if (pix_acc && !out_acc) begin
      pending_next = pending + 1'b1;
    end else if (out_acc && !pix_acc) begin
      pending_next = pending - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pix_s0   <= 1'b0;
      ld_en_s0 <= 1'b0;
      pix_pipe <= '0;
      pending  <= '0;
    end else begin
      pix_s0   <= pix_acc;
      ld_en_s0 <= in_acc && (opcode == OP_LOAD);
      pix_pipe <= {pix_pipe[PIPE_LAT-2:0], pix_s0};
      pending  <= pending_next;
    end
  end

  always_ff @(posedge clk) begin
    sel_s0    <= table_select;
    idx_s0    <= entry_index;
    data_s0   <= entry_value;
    red_s0    <= red_in;
    green_s0  <= green_in;
    blue_s0   <= blue_in;
    alpha_s0  <= alpha_in;
    last_s0   <= last_in;
    last_pipe <= {last_pipe[PIPE_LAT-2:0], last_s0};
  end

  assign ld_s0 = '{en: ld_en_s0, sel: sel_s0, idx: idx_s0, data: data_s0};

  tcm_lane #(
    .CURVE_ENTRIES (CURVE_ENTRIES),
    .TABLE_ID      (TBL_RED),
    .USE_OVERALL   (1'b1)
  ) u_lane_red (
    .clk    (clk),
    .value  (red_s0),
    .ld_in  (ld_s0),
    .result (res_red)
  );

  tcm_lane #(
    .CURVE_ENTRIES (CURVE_ENTRIES),
    .TABLE_ID      (TBL_GREEN),
    .USE_OVERALL   (1'b1)
  ) u_lane_green (
    .clk    (clk),
    .value  (green_s0),
    .ld_in  (ld_s0),
    .result (res_green)
  );

  tcm_lane #(
    .CURVE_ENTRIES (CURVE_ENTRIES),
    .TABLE_ID      (TBL_BLUE),
    .USE_OVERALL   (1'b1)
  ) u_lane_blue (
    .clk    (clk),
    .value  (blue_s0),
    .ld_in  (ld_s0),
    .result (res_blue)
  );

  tcm_lane #(
    .CURVE_ENTRIES (CURVE_ENTRIES),
    .TABLE_ID      (TBL_ALPHA),
    .USE_OVERALL   (1'b0)
  ) u_lane_alpha (
    .clk    (clk),
    .value  (alpha_s0),
    .ld_in  (ld_s0),
    .result (res_alpha)
  );

  assign fifo_in = '{red:   res_red,
                     green: res_green,
                     blue:  res_blue,
                     alpha: res_alpha,
                     last:  last_pipe[PIPE_LAT-1]};

  tcm_out_fifo u_out_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (pix_pipe[PIPE_LAT-1]),
    .wr_data  (fifo_in),
    .rd_valid (out_valid),
    .rd_ready (out_ready),
    .rd_data  (fifo_out)
  );

  assign red_out   = fifo_out.red;
  assign green_out = fifo_out.green;
  assign blue_out  = fifo_out.blue;
  assign alpha_out = fifo_out.alpha;
  assign last_out  = fifo_out.last;

  `ASSERT_ALWAYS(a_pending_bound, clk, rst, pending <= CW'(FIFO_DEPTH), "pending overflow")
  `ASSERT_IMPLIES(a_pipe_credit, clk, rst, pix_pipe[PIPE_LAT-1], pending != '0, "pixel without credit")
  `ASSERT_IMPLIES(a_out_credit, clk, rst, out_valid, pending != '0, "result without credit")
  `ASSERT_NEXT(a_pending_inc, clk, rst, pix_acc && !out_acc, pending == $past(pending) + 1'b1, "pending not advanced")

endmodule

@@ hdl/tcm_map.sv @@
// One curve lookup with linear interpolation and rounding back to Q16.
// Holds its own copy of one curve; uses tcm_pkg.
module tcm_map #(
  parameter int                        CURVE_ENTRIES = 256,
  parameter logic [tcm_pkg::SEL_W-1:0] TABLE_ID      = 3'd0
) (
  input  logic                               clk,
  input  logic signed [tcm_pkg::IN_W-1:0]    value,
  input  tcm_pkg::load_req_t                 ld_in,
  output logic        [tcm_pkg::OUT_W-1:0]   result,
  output tcm_pkg::load_req_t                 ld_out
);
  import tcm_pkg::*;

  localparam int AW = $clog2(CURVE_ENTRIES);
  localparam int TW = FRAC_BITS + AW;
  localparam int MW = BLEND_W + RECIP_W;
  localparam logic [AW-1:0] LAST_IDX = AW'(CURVE_ENTRIES - 1);

  logic [ENTRY_W-1:0] mem [CURVE_ENTRIES];

  logic                 neg1;
  logic                 hi1;
  logic [TW-1:0]        t1;
  load_req_t            ld1;
  logic [AW-1:0]        addr0;
  logic [AW-1:0]        addr1;
  logic [FRAC_BITS-1:0] frac;
  logic                 wr_hit;
  logic [ENTRY_W-1:0]   c0;
  logic [ENTRY_W-1:0]   c1;
  logic [FRAC_BITS-1:0] f2;
  load_req_t            ld2;
  logic [FRAC_BITS:0]   w0;
  logic [BLEND_W:0]     p0;
  logic [BLEND_W:0]     p1;
  logic [BLEND_W-1:0]   n3;
  load_req_t            ld3;
  logic [BLEND_W-1:0]   x3;
  logic [MW-1:0]        prod;

  always_ff @(posedge clk) begin
    neg1 <= value[IN_W-1];
    hi1  <= !value[IN_W-1] && (|value[IN_W-2:FRAC_BITS]);
    t1   <= TW'(value[FRAC_BITS-1:0]) * TW'(LAST_IDX);
    ld1  <= ld_in;
  end

  always_comb begin
    if (neg1) begin
      addr0 = '0;
      frac  = '0;
    end else if (hi1) begin
      addr0 = LAST_IDX;
      frac  = '0;
    end else begin
      addr0 = t1[TW-1:FRAC_BITS];
      frac  = t1[FRAC_BITS-1:0];
    end
    addr1  = (addr0 == LAST_IDX) ? addr0 : addr0 + 1'b1;
    wr_hit = ld1.en && (ld1.sel == TABLE_ID) && (32'(ld1.idx) < CURVE_ENTRIES);
  end

  always_ff @(posedge clk) begin
    if (wr_hit) begin
      mem[AW'(ld1.idx)] <= ld1.data;
    end
    c0  <= mem[addr0];
    c1  <= mem[addr1];
    f2  <= frac;
    ld2 <= ld1;
  end

  always_comb begin
    w0 = ONE_Q - {1'b0, f2};
    p0 = (BLEND_W + 1)'(w0) * (BLEND_W + 1)'(c0);
    p1 = (BLEND_W + 1)'(f2) * (BLEND_W + 1)'(c1);
  end

  always_ff @(posedge clk) begin
    n3  <= BLEND_W'(p0 + p1);
    ld3 <= ld2;
  end

  always_comb begin
    x3   = n3 + ROUND_BIAS;
    prod = MW'(x3) * MW'(RECIP_MUL);
  end

  always_ff @(posedge clk) begin
    result <= prod[RECIP_SHIFT+OUT_W-1:RECIP_SHIFT];
    ld_out <= ld3;
  end

endmodule

@@ hdl/tcm_lane.sv @@
// One channel lane: its own curve, then optionally the overall curve.
// Lanes without the overall curve delay to match. Uses tcm_pkg, tcm_map.
module tcm_lane #(
  parameter int                        CURVE_ENTRIES = 256,
  parameter logic [tcm_pkg::SEL_W-1:0] TABLE_ID      = 3'd1,
  parameter bit                        USE_OVERALL   = 1'b1
) (
  input  logic                             clk,
  input  logic signed [tcm_pkg::IN_W-1:0]  value,
  input  tcm_pkg::load_req_t               ld_in,
  output logic        [tcm_pkg::OUT_W-1:0] result
);
  import tcm_pkg::*;

  logic [OUT_W-1:0] q_a;
  load_req_t        ld_a;

  tcm_map #(
    .CURVE_ENTRIES (CURVE_ENTRIES),
    .TABLE_ID      (TABLE_ID)
  ) u_map_chan (
    .clk    (clk),
    .value  (value),
    .ld_in  (ld_in),
    .result (q_a),
    .ld_out (ld_a)
  );

  generate
    if (USE_OVERALL) begin : g_overall
      tcm_map #(
        .CURVE_ENTRIES (CURVE_ENTRIES),
        .TABLE_ID      (TBL_OVERALL)
      ) u_map_all (
        .clk    (clk),
        .value  (IN_W'({1'b0, q_a})),
        .ld_in  (ld_a),
        .result (result),
        .ld_out ()
      );
    end else begin : g_delay
      logic [OUT_W-1:0] dly [MAP_LAT];
      always_ff @(posedge clk) begin
        dly[0] <= q_a;
        for (int i = 1; i < MAP_LAT; i++) begin
          dly[i] <= dly[i-1];
        end
      end
      assign result = dly[MAP_LAT-1];
    end
  endgenerate

endmodule

@@ hdl/tcm_out_fifo.sv @@
// Merge stage: queues the four lane results and the last flag, with a
// registered output. Uses tcm_pkg.
module tcm_out_fifo (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_en,
  input  tcm_pkg::pix_res_t wr_data,
  output logic              rd_valid,
  input  logic              rd_ready,
  output tcm_pkg::pix_res_t rd_data
);
  import tcm_pkg::*;

  localparam int PW = $clog2(FIFO_DEPTH);
  localparam int CW = $clog2(FIFO_DEPTH + 1);

  pix_res_t      mem [FIFO_DEPTH];
  logic [PW-1:0] rd_ptr;
  logic [PW-1:0] wr_ptr;
  logic [CW-1:0] count;
  logic          load_out;
  logic          take_q;
  logic          bypass;
  logic          push;

  always_comb begin
    load_out = !rd_valid || rd_ready;
    take_q   = load_out && (count != '0);
    bypass   = load_out && (count == '0) && wr_en;
    push     = wr_en && !bypass;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
      rd_ptr   <= '0;
      wr_ptr   <= '0;
      count    <= '0;
    end else begin
      if (load_out) begin
        rd_valid <= (count != '0) || wr_en;
      end
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (take_q) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !take_q) begin
        count <= count + 1'b1;
      end else if (take_q && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_data;
    end
    if (take_q) begin
      rd_data <= mem[rd_ptr];
    end else if (bypass) begin
      rd_data <= wr_data;
    end
  end

endmodule
